>>> hdl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and codes of the heartbeat presence table.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int TIMEOUT_W = 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd5;

  localparam logic ACT_HEARTBEAT = 1'b0;
  localparam logic ACT_TICK      = 1'b1;

  localparam logic [1:0] HB_OFFLINE = 2'd0;
  localparam logic [1:0] HB_ONLINE  = 2'd1;

  typedef enum logic [1:0] {
    OUTCOME_NONE    = 2'd0,
    OUTCOME_ADDED   = 2'd1,
    OUTCOME_UPDATED = 2'd2,
    OUTCOME_DELETED = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLAIM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [SLOT_W-1:0]  slot;
    logic               table_full;
    logic [COUNT_W-1:0] expired_count;
    logic [COUNT_W-1:0] occupied_count;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/hpt_in_if.sv
// ----------------------------------------------------------------------------
// hpt_in_if
// Input channel: heartbeat or tick item with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] user_key;
  logic [1:0]  status;

  modport source (output valid, action, user_key, status, input ready);
  modport sink   (input valid, action, user_key, status, output ready);
endinterface

`default_nettype wire

>>> hdl/hpt_out_if.sv
// ----------------------------------------------------------------------------
// hpt_out_if
// Output channel: one result item per input item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [3:0] slot;
  logic       table_full;
  logic [4:0] expired_count;
  logic [4:0] occupied_count;

  modport source (output valid, outcome, slot, table_full, expired_count, occupied_count,
                  input ready);
  modport sink   (input valid, outcome, slot, table_full, expired_count, occupied_count,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/heartbeat_presence_table.sv
// ----------------------------------------------------------------------------
// heartbeat_presence_table
// Presence table of keyed entries kept alive by heartbeats and aged by ticks.
//
//   channel  dir  handshake     payload
//   beat     in   valid/ready   action, user_key, status
//   result   out  valid/ready   outcome, slot, table_full, expired_count,
//                               occupied_count
//   timeout  in   write enable  timeout_wdata
//
// entries sit in a ring of MAX_ENTRIES cells that rotates one slot a cycle
// past the engine while an item is scanned or claimed; one item is worked
// on at a time. a tick or a heartbeat that matches or is dropped takes one
// rotation of the ring; a heartbeat that claims a slot takes a second
// rotation to write the slot.
// reset empties the table at once and sets the timeout to 5 ticks.
// a stalled result holds in its register; the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_presence_table #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 64,
  parameter int AGE_BITS    = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          timeout_we,
  input  wire logic [hpt_pkg::TIMEOUT_W-1:0] timeout_wdata,
  hpt_in_if.sink                             beat,
  hpt_out_if.source                          result
);

  logic                shift;
  logic                wb_valid;
  logic [KEY_BITS-1:0] wb_key;
  logic [1:0]          wb_status;
  logic [AGE_BITS-1:0] wb_age;

  logic                cell_valid  [MAX_ENTRIES];
  logic [KEY_BITS-1:0] cell_key    [MAX_ENTRIES];
  logic [1:0]          cell_status [MAX_ENTRIES];
  logic [AGE_BITS-1:0] cell_age    [MAX_ENTRIES];

  hpt_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .AGE_BITS    (AGE_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .timeout_we    (timeout_we),
    .timeout_wdata (timeout_wdata),
    .beat          (beat),
    .result        (result),
    .shift         (shift),
    .head_valid    (cell_valid[0]),
    .head_key      (cell_key[0]),
    .head_status   (cell_status[0]),
    .head_age      (cell_age[0]),
    .wb_valid      (wb_valid),
    .wb_key        (wb_key),
    .wb_status     (wb_status),
    .wb_age        (wb_age)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == MAX_ENTRIES - 1) begin : g_tail
      hpt_cell #(
        .KEY_BITS (KEY_BITS),
        .AGE_BITS (AGE_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .in_valid  (wb_valid),
        .in_key    (wb_key),
        .in_status (wb_status),
        .in_age    (wb_age),
        .valid     (cell_valid[i]),
        .key       (cell_key[i]),
        .status    (cell_status[i]),
        .age       (cell_age[i])
      );
    end else begin : g_body
      hpt_cell #(
        .KEY_BITS (KEY_BITS),
        .AGE_BITS (AGE_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .in_valid  (cell_valid[i+1]),
        .in_key    (cell_key[i+1]),
        .in_status (cell_status[i+1]),
        .in_age    (cell_age[i+1]),
        .valid     (cell_valid[i]),
        .key       (cell_key[i]),
        .status    (cell_status[i]),
        .age       (cell_age[i])
      );
    end
  end

endmodule

`default_nettype wire

>>> hdl/hpt_cell.sv
// ----------------------------------------------------------------------------
// hpt_cell
// One table entry of the rotating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_cell #(
  parameter int KEY_BITS = 64,
  parameter int AGE_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                shift,
  input  wire logic                in_valid,
  input  wire logic [KEY_BITS-1:0] in_key,
  input  wire logic [1:0]          in_status,
  input  wire logic [AGE_BITS-1:0] in_age,
  output logic                     valid,
  output logic [KEY_BITS-1:0]      key,
  output logic [1:0]               status,
  output logic [AGE_BITS-1:0]      age
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key    <= in_key;
      status <= in_status;
      age    <= in_age;
    end
  end

endmodule

`default_nettype wire

>>> hdl/hpt_engine.sv
// ----------------------------------------------------------------------------
// hpt_engine
// Head of the ring: matches, ages, frees and claims entries as they pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_engine #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 64,
  parameter int AGE_BITS    = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  timeout_we,
  input  wire logic [hpt_pkg::TIMEOUT_W-1:0] timeout_wdata,
  hpt_in_if.sink                     beat,
  hpt_out_if.source                  result,
  output logic                       shift,
  input  wire logic                  head_valid,
  input  wire logic [KEY_BITS-1:0]   head_key,
  input  wire logic [1:0]            head_status,
  input  wire logic [AGE_BITS-1:0]   head_age,
  output logic                       wb_valid,
  output logic [KEY_BITS-1:0]        wb_key,
  output logic [1:0]                 wb_status,
  output logic [AGE_BITS-1:0]        wb_age
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (AGE_BITS > hpt_pkg::TIMEOUT_W) ? AGE_BITS : hpt_pkg::TIMEOUT_W;
  localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

  hpt_pkg::state_t state, state_next;

  logic [hpt_pkg::TIMEOUT_W-1:0] timeout;
  logic                  action;
  logic [KEY_BITS-1:0]   key;
  logic [1:0]            status;
  logic [IDX_W-1:0]      step;
  logic                  matched;
  logic [IDX_W-1:0]      match_idx;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [CNT_W-1:0]      vcount;
  logic [CNT_W-1:0]      expired;
  logic                  out_valid;
  hpt_pkg::result_t      out_data;

  logic [AGE_BITS-1:0]   age_inc;
  logic                  aged_out;
  logic                  hit;
  logic                  free_hit;
  logic                  claim_hit;
  logic                  expire_now;
  logic                  need_claim;
  logic                  can_load;
  logic [IDX_W-1:0]      step_inc;
  hpt_pkg::result_t      res;

  assign age_inc  = (head_age == AGE_MAX) ? head_age : head_age + AGE_BITS'(1);
  assign aged_out = CMP_W'(age_inc) > CMP_W'(timeout);
  assign step_inc = (step == LAST_IDX) ? '0 : step + IDX_W'(1);

  assign hit = (state == hpt_pkg::ST_SCAN) && (action == hpt_pkg::ACT_HEARTBEAT) &&
               head_valid && (head_key == key) && !matched;
  assign free_hit = (state == hpt_pkg::ST_SCAN) && (action == hpt_pkg::ACT_HEARTBEAT) &&
                    !head_valid && !free_found;
  assign claim_hit  = (state == hpt_pkg::ST_CLAIM) && (step == free_idx);
  assign expire_now = (state == hpt_pkg::ST_SCAN) && (action == hpt_pkg::ACT_TICK) &&
                      head_valid && aged_out;
  assign need_claim = (action == hpt_pkg::ACT_HEARTBEAT) && !(matched || hit) &&
                      (free_found || free_hit) && (status == hpt_pkg::HB_ONLINE);
  assign can_load   = !out_valid || result.ready;

  // write-back of the head entry into the tail of the ring
  always_comb begin
    wb_valid  = head_valid;
    wb_key    = head_key;
    wb_status = head_status;
    wb_age    = head_age;
    case (state)
      hpt_pkg::ST_SCAN: begin
        if (action == hpt_pkg::ACT_TICK) begin
          if (head_valid) begin
            if (aged_out) begin
              wb_valid = 1'b0;
            end else begin
              wb_age = age_inc;
            end
          end
        end else if (hit) begin
          if (status == hpt_pkg::HB_OFFLINE) begin
            wb_valid = 1'b0;
          end else begin
            wb_status = status;
            wb_age    = '0;
          end
        end
      end
      hpt_pkg::ST_CLAIM: begin
        if (claim_hit) begin
          wb_valid  = 1'b1;
          wb_key    = key;
          wb_status = status;
          wb_age    = '0;
        end
      end
      default: ;
    endcase
  end

  // result of the finished item
  always_comb begin
    res.outcome        = hpt_pkg::OUTCOME_NONE;
    res.slot           = '0;
    res.table_full     = 1'b0;
    res.expired_count  = hpt_pkg::COUNT_W'(expired);
    res.occupied_count = hpt_pkg::COUNT_W'(vcount);
    if (action == hpt_pkg::ACT_HEARTBEAT) begin
      if (matched) begin
        res.slot    = hpt_pkg::SLOT_W'(match_idx);
        res.outcome = (status == hpt_pkg::HB_OFFLINE) ?
                      hpt_pkg::OUTCOME_DELETED : hpt_pkg::OUTCOME_UPDATED;
      end else if (!free_found) begin
        res.table_full = 1'b1;
      end else if (status == hpt_pkg::HB_ONLINE) begin
        res.slot    = hpt_pkg::SLOT_W'(free_idx);
        res.outcome = hpt_pkg::OUTCOME_ADDED;
      end
    end
  end

  always_comb begin
    state_next = state;
    shift      = 1'b0;
    beat.ready = 1'b0;
    case (state)
      hpt_pkg::ST_IDLE: begin
        beat.ready = 1'b1;
        if (beat.valid) begin
          state_next = hpt_pkg::ST_SCAN;
        end
      end
      hpt_pkg::ST_SCAN: begin
        shift = 1'b1;
        if (step == LAST_IDX) begin
          state_next = need_claim ? hpt_pkg::ST_CLAIM : hpt_pkg::ST_FINISH;
        end
      end
      hpt_pkg::ST_CLAIM: begin
        shift = 1'b1;
        if (step == LAST_IDX) begin
          state_next = hpt_pkg::ST_FINISH;
        end
      end
      hpt_pkg::ST_FINISH: begin
        if (can_load) begin
          state_next = hpt_pkg::ST_IDLE;
        end
      end
      default: state_next = hpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout   <= hpt_pkg::TIMEOUT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (timeout_we) begin
        timeout <= timeout_wdata;
      end
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if ((state == hpt_pkg::ST_FINISH) && can_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      hpt_pkg::ST_IDLE: begin
        if (beat.valid) begin
          action     <= beat.action;
          key        <= beat.user_key[KEY_BITS-1:0];
          status     <= beat.status;
          step       <= '0;
          matched    <= 1'b0;
          free_found <= 1'b0;
          vcount     <= '0;
          expired    <= '0;
        end
      end
      hpt_pkg::ST_SCAN: begin
        step <= step_inc;
        if (hit) begin
          matched   <= 1'b1;
          match_idx <= step;
        end
        if (free_hit) begin
          free_found <= 1'b1;
          free_idx   <= step;
        end
        if (wb_valid) begin
          vcount <= vcount + CNT_W'(1);
        end
        if (expire_now) begin
          expired <= expired + CNT_W'(1);
        end
      end
      hpt_pkg::ST_CLAIM: begin
        step <= step_inc;
        if (claim_hit) begin
          vcount <= vcount + CNT_W'(1);
        end
      end
      hpt_pkg::ST_FINISH: begin
        if (can_load) begin
          out_data <= res;
        end
      end
      default: ;
    endcase
  end

  assign result.valid          = out_valid;
  assign result.outcome        = out_data.outcome;
  assign result.slot           = out_data.slot;
  assign result.table_full     = out_data.table_full;
  assign result.expired_count  = out_data.expired_count;
  assign result.occupied_count = out_data.occupied_count;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (beat.valid && beat.ready) |=> (state == hpt_pkg::ST_SCAN && step == '0))
    else $error("accepted item did not start a scan at slot zero");

  a_scan_ends_on_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == hpt_pkg::ST_SCAN && step == LAST_IDX) |=> (state != hpt_pkg::ST_SCAN))
    else $error("scan ran past the last slot");

  a_claim_has_free: assert property (@(posedge clk) disable iff (rst)
    (state == hpt_pkg::ST_CLAIM) |-> (free_found && !matched))
    else $error("claim pass without a free slot");

  a_added_not_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.outcome == hpt_pkg::OUTCOME_ADDED) |->
    (!out_data.table_full && out_data.expired_count == '0))
    else $error("added entry reported with full table or expiries");

endmodule

`default_nettype wire
